// File: hw/rtl/trg_pkg.sv
// Shared widths, codes and types of the thermal runaway guard.
`timescale 1ns / 1ps

package trg_pkg;

    // Field widths
    localparam int TEMP_W    = 16;
    localparam int TIME_W    = 32;
    localparam int HYST_W    = 10;
    localparam int RISE_W    = 11;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Internal width for band and rise arithmetic on temperatures.
    localparam int CALC_W = TEMP_W + 2;

    // Length of one rise check period in milliseconds.
    localparam logic [TIME_W-1:0] CHECK_PERIOD_MS = TIME_W'(1000);

    // Guard mode codes
    localparam logic [MODE_W-1:0] MODE_INACTIVE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RAMPUP   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SLOW     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_AT_TEMP  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OUT_BAND = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RUNAWAY  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_WATCHDOG = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_WATCHDOG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RISE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP      = 3'd5;

    // Configuration values as seen by the step logic.
    typedef struct packed {
        logic        [TIME_W-1:0] ramp_watchdog_ms;
        logic        [TIME_W-1:0] hold_watchdog_ms;
        logic        [HYST_W-1:0] hysteresis_deg;
        logic signed [RISE_W-1:0] min_rise_deg;
        logic signed [TEMP_W-1:0] min_allowed_temp;
        logic signed [TEMP_W-1:0] max_allowed_temp;
    } t_cfg;

    // One input sample.
    typedef struct packed {
        logic signed [TEMP_W-1:0] measured_temp;
        logic signed [TEMP_W-1:0] setpoint;
        logic        [TIME_W-1:0] now_ms;
    } t_sample;

    // Guard state carried from one sample to the next.
    typedef struct packed {
        logic        [MODE_W-1:0] mode;
        logic signed [TEMP_W-1:0] last_check_temp;
        logic        [TIME_W-1:0] check_deadline_ms;
        logic        [TIME_W-1:0] watchdog_start_ms;
    } t_state;

    // One result item.
    typedef struct packed {
        logic [MODE_W-1:0] guard_state;
        logic              shutdown_request;
    } t_result;

endpackage

// File: hw/rtl/trg_if.sv
// Channel interfaces of the thermal runaway guard: samples, results and configuration.
`timescale 1ns / 1ps

interface trg_sample_if;
    import trg_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] measured_temp;
    logic signed [TEMP_W-1:0] setpoint;
    logic        [TIME_W-1:0] now_ms;

    modport source (output valid, measured_temp, setpoint, now_ms, input ready);
    modport sink   (input valid, measured_temp, setpoint, now_ms, output ready);
endinterface

interface trg_result_if;
    import trg_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] guard_state;
    logic              shutdown_request;

    modport source (output valid, guard_state, shutdown_request, input ready);
    modport sink   (input valid, guard_state, shutdown_request, output ready);
endinterface

interface trg_cfg_if;
    import trg_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/trg_cfg_regs.sv
// Configuration register file of the thermal runaway guard.
`timescale 1ns / 1ps

module trg_cfg_regs
    import trg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    trg_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;

    // Decode the index of each transfer and load the addressed register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_RAMP_WATCHDOG: begin
                    r_cfg.ramp_watchdog_ms <= i_cfg.data[TIME_W-1:0];
                end
                REG_HOLD_WATCHDOG: begin
                    r_cfg.hold_watchdog_ms <= i_cfg.data[TIME_W-1:0];
                end
                REG_HYSTERESIS: begin
                    r_cfg.hysteresis_deg <= i_cfg.data[HYST_W-1:0];
                end
                REG_MIN_RISE: begin
                    r_cfg.min_rise_deg <= i_cfg.data[RISE_W-1:0];
                end
                REG_MIN_TEMP: begin
                    r_cfg.min_allowed_temp <= i_cfg.data[TEMP_W-1:0];
                end
                REG_MAX_TEMP: begin
                    r_cfg.max_allowed_temp <= i_cfg.data[TEMP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/trg_step_logic.sv
// Combinational next-state and result logic of the guard for one sample.
`timescale 1ns / 1ps

module trg_step_logic
    import trg_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_sample i_sample,
    input  t_state  i_state,
    output t_state  o_state,
    output t_result o_result
);

    logic signed [CALC_W-1:0] w_temp;
    logic signed [CALC_W-1:0] w_band_lo;
    logic signed [CALC_W-1:0] w_band_hi;
    logic signed [CALC_W-1:0] w_rise;
    logic signed [CALC_W-1:0] w_min_rise;
    logic signed [TEMP_W-1:0] w_last;
    logic        [TIME_W-1:0] w_next_deadline;
    logic        [TIME_W-1:0] w_elapsed;
    logic [MODE_W-1:0]        w_mode;
    logic                     w_target_zero;
    logic                     w_target_pos;
    logic                     w_out_window;
    logic                     w_in_band;
    logic                     w_rise_ok;
    logic                     w_deadline_hit;
    logic                     w_shutdown;

    // Band, rise, window and timer checks on the current sample.
    always_comb begin
        w_target_zero = (i_sample.setpoint == '0);
        w_target_pos  = !w_target_zero && !i_sample.setpoint[TEMP_W-1];
        w_last        = w_target_zero ? '0 : i_state.last_check_temp;

        w_temp     = CALC_W'(i_sample.measured_temp);
        w_band_lo  = CALC_W'(i_sample.setpoint) - CALC_W'(signed'({1'b0, i_cfg.hysteresis_deg}));
        w_band_hi  = CALC_W'(i_sample.setpoint) + CALC_W'(signed'({1'b0, i_cfg.hysteresis_deg}));
        w_in_band  = (w_temp >= w_band_lo) && (w_temp <= w_band_hi);

        w_rise     = w_temp - CALC_W'(w_last);
        w_min_rise = CALC_W'(i_cfg.min_rise_deg);
        w_rise_ok  = (w_rise >= w_min_rise);

        w_out_window = (i_sample.measured_temp > i_cfg.max_allowed_temp) ||
                       (i_sample.measured_temp < i_cfg.min_allowed_temp);

        w_deadline_hit  = (i_state.check_deadline_ms <= i_sample.now_ms);
        w_next_deadline = i_sample.now_ms + CHECK_PERIOD_MS;
        w_elapsed       = i_sample.now_ms - i_state.watchdog_start_ms;
    end

    // Mode transitions: zero target first, then the window, then the mode itself.
    always_comb begin
        w_mode = i_state.mode;
        if (w_target_zero) begin
            w_mode = MODE_INACTIVE;
        end
        if (w_out_window) begin
            w_mode = MODE_RUNAWAY;
        end

        o_state                 = i_state;
        o_state.last_check_temp = w_last;
        o_state.mode            = w_mode;
        w_shutdown              = 1'b0;

        case (w_mode)
            MODE_INACTIVE: begin
                if (w_target_pos) begin
                    o_state.mode              = MODE_RAMPUP;
                    o_state.last_check_temp   = i_sample.measured_temp;
                    o_state.check_deadline_ms = w_next_deadline;
                end
            end
            MODE_RAMPUP: begin
                if (w_deadline_hit) begin
                    if (!w_rise_ok) begin
                        o_state.watchdog_start_ms = i_sample.now_ms;
                        o_state.mode              = MODE_SLOW;
                    end
                    o_state.last_check_temp   = i_sample.measured_temp;
                    o_state.check_deadline_ms = w_next_deadline;
                end
                if (w_in_band) begin
                    o_state.mode = MODE_AT_TEMP;
                end
            end
            MODE_SLOW: begin
                if (w_deadline_hit) begin
                    if (w_rise_ok) begin
                        o_state.mode = MODE_RAMPUP;
                    end
                    o_state.last_check_temp   = i_sample.measured_temp;
                    o_state.check_deadline_ms = w_next_deadline;
                end
                if (w_elapsed >= i_cfg.ramp_watchdog_ms) begin
                    o_state.mode = MODE_RUNAWAY;
                end
            end
            MODE_AT_TEMP: begin
                if (!w_in_band) begin
                    o_state.watchdog_start_ms = i_sample.now_ms;
                    o_state.mode              = MODE_OUT_BAND;
                end
            end
            MODE_OUT_BAND: begin
                if (w_in_band) begin
                    o_state.mode = MODE_AT_TEMP;
                end else if (w_elapsed >= i_cfg.hold_watchdog_ms) begin
                    o_state.mode = MODE_RUNAWAY;
                end
            end
            MODE_RUNAWAY: begin
                w_shutdown = 1'b1;
            end
            default: begin
            end
        endcase

        o_result.guard_state      = o_state.mode;
        o_result.shutdown_request = w_shutdown;
    end

endmodule

// File: hw/rtl/thermal_runaway_guard.sv
// Top level of the thermal runaway guard: sample register, guard state and result register.
//
// The block watches a heater. Each transfer on i_sample carries one temperature
// reading, the commanded target and the current millisecond time; each sample
// gives exactly one transfer on o_result with the guard state after that sample
// and a shutdown request flag. Configuration registers are loaded through i_cfg
// (index 0 to 5, as listed in the package); the user must load them only while
// no sample is in flight (the block does not enforce it); i_cfg is always ready.
//
// A sample that is taken is loaded into the sample register, evaluated against
// the guard state by the combinational step logic and loaded, with the new guard
// state, into the result register, from which it is shown on o_result. The block
// takes one sample per cycle while the receiver keeps o_result.ready high, set by
// the step logic between the two registers.
//
// Reset clears the guard to inactive, the check and watchdog times and the
// last check temperature to zero, all configuration registers to zero, and
// empties both registers. When the receiver stalls, the result register holds
// its item and the sample register can still take one more sample; after that
// i_sample.ready stays low until the result is taken.
`timescale 1ns / 1ps

module thermal_runaway_guard
    import trg_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    trg_sample_if.sink    i_sample,
    trg_cfg_if.sink       i_cfg,
    trg_result_if.source  o_result
);

    t_cfg    w_cfg;
    t_sample r_in;
    logic    r_in_valid;
    t_state  r_state;
    t_state  w_state_next;
    t_result w_result;
    t_result r_out;
    logic    r_out_valid;
    logic    w_advance;

    // Configuration registers.
    trg_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // A held sample moves on when the result register is free or is being emptied.
    assign w_advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_in_valid || w_advance;

    // Sample register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.ready && i_sample.valid) begin
            r_in.measured_temp <= i_sample.measured_temp;
            r_in.setpoint      <= i_sample.setpoint;
            r_in.now_ms        <= i_sample.now_ms;
        end
    end

    // Step logic for the held sample.
    trg_step_logic u_step_logic (
        .i_cfg    (w_cfg),
        .i_sample (r_in),
        .i_state  (r_state),
        .o_state  (w_state_next),
        .o_result (w_result)
    );

    // Guard state is committed together with the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: MODE_INACTIVE, default: '0};
        end else if (w_advance) begin
            r_state <= w_state_next;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.guard_state      = r_out.guard_state;
    assign o_result.shutdown_request = r_out.shutdown_request;

    // A shutdown request is only ever shown together with the runaway state.
    a_shutdown_runaway: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.shutdown_request) |-> (r_out.guard_state == MODE_RUNAWAY))
        else $error("shutdown request without runaway state");

    // The committed mode stays within the six guard modes.
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode <= MODE_RUNAWAY))
        else $error("guard mode out of range");

    // The result of a step carries the mode that the same step committed.
    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (r_out_valid && (r_out.guard_state == r_state.mode)))
        else $error("result state differs from committed state");

    // A sample that cannot move on stays in the sample register.
    a_sample_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in)))
        else $error("stalled sample lost");

endmodule

// File: tb/sv/tb_thermal_runaway_guard.sv
// Self-checking testbench for the thermal runaway guard with a built-in guard predictor.
`timescale 1ns / 1ps

module tb_thermal_runaway_guard;
    import trg_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int HOLD_AT_SAMPLE   = 150;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES    = 10;
    localparam int PHASE_ITEMS      = 170;
    localparam int MAX_REPORTS      = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    trg_sample_if sample_if ();
    trg_cfg_if    cfg_if ();
    trg_result_if result_if ();

    thermal_runaway_guard u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_if),
        .i_cfg    (cfg_if),
        .o_result (result_if)
    );

    // Samples waiting to be offered and guard results still to arrive.
    t_sample pending_samples[$];
    t_result expected_results[$];
    t_sample offered_sample;

    // Predicted guard state and the configuration it runs with.
    t_cfg              cfg_shadow    = '0;
    logic [MODE_W-1:0] cur_mode      = MODE_INACTIVE;
    int                rise_ref_temp = 0;
    logic [TIME_W-1:0] next_check_ms = '0;
    logic [TIME_W-1:0] watch_from_ms = '0;

    // Handshake pacing.
    int   tx_gap       = 0;
    int   rx_gap       = 0;
    int   samples_sent = 0;
    int   fail_count   = 0;
    int   cycle_count  = 0;
    logic steady_phase = 1'b0;
    logic long_hold    = 1'b0;

    // Trajectory of the simulated heater for random phases.
    int                sim_temp;
    int                sim_target;
    int                sim_rate;
    logic [TIME_W-1:0] sim_now;

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Advance the predicted guard by one sample and return the result it gives.
    function automatic t_result step_guard_model(input t_sample s);
        int                temp;
        int                target;
        int                hyst;
        logic              band_ok;
        logic [TIME_W-1:0] elapsed;
        t_result           res;
        temp    = int'(s.measured_temp);
        target  = int'(s.setpoint);
        hyst    = int'(cfg_shadow.hysteresis_deg);
        band_ok = (temp >= target - hyst) && (temp <= target + hyst);
        elapsed = s.now_ms - watch_from_ms;
        res.shutdown_request = 1'b0;

        // A zero target turns the guard off; a reading outside the window overrides it.
        if (target == 0) begin
            rise_ref_temp = 0;
            cur_mode      = MODE_INACTIVE;
        end
        if (temp > int'(cfg_shadow.max_allowed_temp) || temp < int'(cfg_shadow.min_allowed_temp))
            cur_mode = MODE_RUNAWAY;

        case (cur_mode)
            MODE_INACTIVE: begin
                if (target > 0) begin
                    cur_mode      = MODE_RAMPUP;
                    rise_ref_temp = temp;
                    next_check_ms = s.now_ms + CHECK_PERIOD_MS;
                end
            end
            MODE_RAMPUP: begin
                if (next_check_ms <= s.now_ms) begin
                    if (temp - rise_ref_temp < int'(cfg_shadow.min_rise_deg)) begin
                        watch_from_ms = s.now_ms;
                        cur_mode      = MODE_SLOW;
                    end
                    rise_ref_temp = temp;
                    next_check_ms = s.now_ms + CHECK_PERIOD_MS;
                end
                if (band_ok)
                    cur_mode = MODE_AT_TEMP;
            end
            MODE_SLOW: begin
                if (next_check_ms <= s.now_ms) begin
                    if (temp - rise_ref_temp >= int'(cfg_shadow.min_rise_deg))
                        cur_mode = MODE_RAMPUP;
                    rise_ref_temp = temp;
                    next_check_ms = s.now_ms + CHECK_PERIOD_MS;
                end
                if (elapsed >= cfg_shadow.ramp_watchdog_ms)
                    cur_mode = MODE_RUNAWAY;
            end
            MODE_AT_TEMP: begin
                if (!band_ok) begin
                    watch_from_ms = s.now_ms;
                    cur_mode      = MODE_OUT_BAND;
                end
            end
            MODE_OUT_BAND: begin
                if (band_ok)
                    cur_mode = MODE_AT_TEMP;
                else if (elapsed >= cfg_shadow.hold_watchdog_ms)
                    cur_mode = MODE_RUNAWAY;
            end
            MODE_RUNAWAY: begin
                res.shutdown_request = 1'b1;
            end
            default: begin
            end
        endcase

        res.guard_state = cur_mode;
        return res;
    endfunction

    function automatic logic signed [TEMP_W-1:0] clamp16(input int v);
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return TEMP_W'(v);
    endfunction

    // Write one register and mirror it once the transfer has happened.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        case (idx)
            REG_RAMP_WATCHDOG: cfg_shadow.ramp_watchdog_ms = value;
            REG_HOLD_WATCHDOG: cfg_shadow.hold_watchdog_ms = value;
            REG_HYSTERESIS:    cfg_shadow.hysteresis_deg   = value[HYST_W-1:0];
            REG_MIN_RISE:      cfg_shadow.min_rise_deg     = value[RISE_W-1:0];
            REG_MIN_TEMP:      cfg_shadow.min_allowed_temp = value[TEMP_W-1:0];
            REG_MAX_TEMP:      cfg_shadow.max_allowed_temp = value[TEMP_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic apply_config(input logic [TIME_W-1:0] ramp, input logic [TIME_W-1:0] hold,
                                input int hyst, input int rise, input int lo, input int hi);
        write_reg(REG_RAMP_WATCHDOG, ramp);
        write_reg(REG_HOLD_WATCHDOG, hold);
        write_reg(REG_HYSTERESIS, CFG_DAT_W'(hyst));
        write_reg(REG_MIN_RISE, CFG_DAT_W'(rise));
        write_reg(REG_MIN_TEMP, CFG_DAT_W'(lo));
        write_reg(REG_MAX_TEMP, CFG_DAT_W'(hi));
        cfg_if.valid <= 1'b0;
    endtask

    // Draw a setting per register, with the extremes showing up often.
    task automatic randomize_config();
        logic [TIME_W-1:0] ramp;
        logic [TIME_W-1:0] hold;
        int                hyst;
        int                rise;
        int                lo;
        int                hi;
        case ($urandom_range(0, 5))
            0:       ramp = '0;
            1:       ramp = '1;
            2, 3:    ramp = $urandom;
            default: ramp = $urandom_range(300, 6000);
        endcase
        case ($urandom_range(0, 5))
            0:       hold = '0;
            1:       hold = '1;
            2, 3:    hold = $urandom;
            default: hold = $urandom_range(300, 6000);
        endcase
        case ($urandom_range(0, 5))
            0:       hyst = 0;
            1:       hyst = 1023;
            2, 3:    hyst = $urandom_range(0, 1023);
            default: hyst = $urandom_range(1, 15);
        endcase
        case ($urandom_range(0, 5))
            0:       rise = -1023;
            1:       rise = 1023;
            2, 3:    rise = int'($urandom_range(0, 2046)) - 1023;
            default: rise = $urandom_range(0, 25);
        endcase
        case ($urandom_range(0, 5))
            0:       lo = -32768;
            1, 2:    lo = int'($urandom_range(0, 65535)) - 32768;
            default: lo = -int'($urandom_range(0, 60));
        endcase
        case ($urandom_range(0, 5))
            0:       hi = 32767;
            1, 2:    hi = int'($urandom_range(0, 65535)) - 32768;
            default: hi = $urandom_range(450, 1500);
        endcase
        apply_config(ramp, hold, hyst, rise, lo, hi);
    endtask

    task automatic add_sample(input int meas, input int tgt, input logic [TIME_W-1:0] now);
        t_sample s;
        s.measured_temp = clamp16(meas);
        s.setpoint      = clamp16(tgt);
        s.now_ms        = now;
        pending_samples.push_back(s);
    endtask

    // A heater that ramps toward its target and then hovers, with noise and faults mixed in.
    task automatic add_random_items(input int count);
        int      k;
        int      pick;
        int      meas;
        int      band;
        t_sample s;
        sim_rate   = $urandom_range(0, 40);
        sim_temp   = $urandom_range(0, 40);
        sim_target = $urandom_range(50, 400);
        if ($urandom_range(0, 2) == 0)
            sim_now = 32'hFFFF_FFFF - $urandom_range(0, 20000);
        else
            sim_now = $urandom;
        band = int'(cfg_shadow.hysteresis_deg) + 3;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 7) == 0)
                sim_now = sim_now + $urandom_range(0, 3000);
            else
                sim_now = sim_now + $urandom_range(50, 600);
            if (pick < 4) begin
                s.measured_temp = TEMP_W'($urandom);
                s.setpoint      = TEMP_W'($urandom);
                s.now_ms        = $urandom;
            end else begin
                if (pick < 7)
                    sim_target = 0;
                else if (pick < 9)
                    sim_target = -int'($urandom_range(1, 500));
                else if (pick < 11 || sim_target <= 0)
                    sim_target = $urandom_range(50, 400);
                if (sim_target <= 0)
                    sim_temp = sim_temp - int'($urandom_range(0, 10));
                else if (pick < 16)
                    sim_temp = sim_temp - int'($urandom_range(0, 60));
                else if (sim_temp < sim_target - band)
                    sim_temp = sim_temp + int'($urandom_range(0, sim_rate));
                else
                    sim_temp = sim_target + int'($urandom_range(0, 2 * band)) - band;
                if (sim_temp > 2000)
                    sim_temp = 2000;
                else if (sim_temp < -1000)
                    sim_temp = -1000;
                meas = sim_temp;
                if (pick >= 16 && pick < 18)
                    meas = int'(cfg_shadow.max_allowed_temp) + int'($urandom_range(1, 20));
                else if (pick == 18)
                    meas = int'(cfg_shadow.min_allowed_temp) - int'($urandom_range(1, 20));
                s.measured_temp = clamp16(meas);
                s.setpoint      = clamp16(sim_target);
                s.now_ms        = sim_now;
            end
            pending_samples.push_back(s);
        end
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || sample_if.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Sample driver: offers queued samples with a random gap after each transfer.
    always @(posedge i_clk) begin : sample_driver
        int gap;
        if (!i_rst_n) begin
            sample_if.valid <= 1'b0;
            tx_gap          <= 0;
        end else begin
            gap = (tx_gap > 0) ? tx_gap - 1 : 0;
            if (sample_if.valid && sample_if.ready) begin
                expected_results.push_back(step_guard_model(offered_sample));
                samples_sent <= samples_sent + 1;
                gap = steady_phase ? 0 : $urandom_range(0, 5);
            end
            if (!sample_if.valid || sample_if.ready) begin
                if (gap == 0 && pending_samples.size() > 0) begin
                    offered_sample          = pending_samples.pop_front();
                    sample_if.valid         <= 1'b1;
                    sample_if.measured_temp <= offered_sample.measured_temp;
                    sample_if.setpoint      <= offered_sample.setpoint;
                    sample_if.now_ms        <= offered_sample.now_ms;
                end else begin
                    sample_if.valid <= 1'b0;
                end
            end
            tx_gap <= gap;
        end
    end

    // Result monitor: checks each transfer against the oldest prediction and paces ready.
    always @(posedge i_clk) begin : result_monitor
        int      gap;
        t_result want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            rx_gap          <= 0;
        end else begin
            gap = (rx_gap > 0) ? rx_gap - 1 : 0;
            if (result_if.valid && result_if.ready) begin
                gap = steady_phase ? 0 : $urandom_range(0, 5);
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: state %0d shutdown %0b",
                                 result_if.guard_state, result_if.shutdown_request);
                end else begin
                    want = expected_results.pop_front();
                    if (result_if.guard_state !== want.guard_state ||
                        result_if.shutdown_request !== want.shutdown_request) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("mismatch: state exp %0d got %0d, shutdown exp %0b got %0b",
                                     want.guard_state, result_if.guard_state,
                                     want.shutdown_request, result_if.shutdown_request);
                    end
                end
            end
            rx_gap          <= gap;
            result_if.ready <= !long_hold && gap == 0;
        end
    end

    // One long receiver stall while the sender keeps offering samples.
    initial begin : receiver_hold_off
        wait (samples_sent >= HOLD_AT_SAMPLE);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Main sequence: reset, directed phases, then random phases with fresh settings.
    initial begin : main_sequence
        int ph;
        i_rst_n      = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_RAMP_WATCHDOG;
        cfg_if.data  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Ramp, slow ramp, hold band, both watchdogs, window faults and a wrapped deadline.
        apply_config(32'd3000, 32'd2000, 5, 10, -20, 300);
        add_sample(25, 0, 32'd0);
        add_sample(25, -50, 32'd10);
        add_sample(25, 200, 32'd100);
        add_sample(32, 200, 32'd1100);
        add_sample(50, 200, 32'd2100);
        add_sample(197, 200, 32'd2200);
        add_sample(210, 200, 32'd2300);
        add_sample(190, 200, 32'd4500);
        add_sample(190, 200, 32'd4600);
        add_sample(400, 0, 32'd4700);
        add_sample(100, 0, 32'd4800);
        add_sample(-30, 200, 32'd4900);
        add_sample(32767, 0, 32'd5100);
        add_sample(-32768, 100, 32'd5200);
        add_sample(25, 0, 32'd5300);
        add_sample(25, 200, 32'hFFFF_FF00);
        add_sample(26, 200, 32'hFFFF_FF10);
        add_sample(27, 200, 32'h0000_0010);
        add_sample(27, 200, 32'h0000_0400);
        add_sample(28, 200, 32'h0000_0C00);
        wait_idle();

        // Zero watchdogs expire on the next slow or out-of-band sample; full window, no band.
        apply_config(32'd0, 32'd0, 0, 1023, -32768, 32767);
        add_sample(5, 100, 32'd0);
        add_sample(5, 100, 32'd1000);
        add_sample(100, 100, 32'd1100);
        add_sample(100, 0, 32'd1200);
        add_sample(101, 100, 32'd1300);
        add_sample(100, 100, 32'd1400);
        add_sample(101, 100, 32'd1500);
        add_sample(101, 100, 32'hFFFF_FFFF);
        wait_idle();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            steady_phase <= (ph % 4 == 2);
            randomize_config();
            add_random_items(PHASE_ITEMS);
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
